[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Each use samples on clk_i and is
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequence must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/idq_pkg.sv]
package idq_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK = 3'd0,
    CMD_READ      = 3'd1,
    CMD_POP_FRONT = 3'd2,
    CMD_POP_BACK  = 3'd3,
    CMD_REMOVE    = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle action broadcast to every cell of the row.
  typedef struct packed {
    logic push;
    logic remove;
  } cell_op_t;

  // Outcome of one command, as seen by the result register.
  typedef struct packed {
    status_e status;
    logic    rd_en;
  } cmd_res_t;

endpackage

[rtl/core/idq_cell.sv]
module idq_cell import idq_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  cell_op_t         op_i,
  input  logic [IDX_W-1:0] tgt_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [WIDTH-1:0] next_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q;
  logic [WIDTH-1:0] data_d;
  logic             is_tgt;
  logic             at_or_after;

  assign is_tgt      = (tgt_i == IDX_W'(INDEX));
  assign at_or_after = (tgt_i <= IDX_W'(INDEX));

  // A push lands in the cell at the current count; a removal pulls every cell
  // from the removed place onwards one step towards the front.
  always_comb begin
    data_d = data_q;
    if (op_i.push && is_tgt) begin
      data_d = wdata_i;
    end else if (op_i.remove && at_or_after) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/core/idq_ctrl.sv]
module idq_ctrl import idq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [POS_W-1:0] pos_i,
  output cell_op_t         op_o,
  output logic [IDX_W-1:0] tgt_o,
  output cmd_res_t         res_o,
  output logic [CNT_W-1:0] count_o,
  output logic [CNT_W-1:0] count_next_o
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] cnt_m1;
  logic             pos_ok;
  logic             nonempty;
  logic             full;
  cell_op_t         op;
  cmd_res_t         res;
  logic [IDX_W-1:0] tgt;

  assign pos_ext  = CMP_W'(pos_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign pos_ok   = (pos_ext < cnt_ext);
  assign nonempty = (count_q != '0);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign cnt_m1   = count_q - CNT_W'(1);

  always_comb begin
    op         = '0;
    res.status = ST_OK;
    res.rd_en  = 1'b0;
    tgt        = '0;
    case (cmd_e'(cmd_i))
      CMD_PUSH_BACK: begin
        tgt = count_q[IDX_W-1:0];
        if (full) begin
          res.status = ST_FULL;
        end else begin
          op.push = 1'b1;
        end
      end
      CMD_READ: begin
        tgt = pos_ext[IDX_W-1:0];
        if (pos_ok) begin
          res.rd_en = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_POP_FRONT: begin
        if (nonempty) begin
          res.rd_en = 1'b1;
          op.remove = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_POP_BACK: begin
        tgt = cnt_m1[IDX_W-1:0];
        if (nonempty) begin
          res.rd_en = 1'b1;
          op.remove = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_REMOVE: begin
        tgt = pos_ext[IDX_W-1:0];
        if (pos_ok) begin
          res.rd_en = 1'b1;
          op.remove = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: begin
        res.status = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (op.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.remove) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  // Cells only move on an accepted transaction.
  assign op_o.push    = op.push & fire_i;
  assign op_o.remove  = op.remove & fire_i;
  assign tgt_o        = tgt;
  assign res_o        = res;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

[rtl/core/indexed_deque_with_removal.sv]
// Indexed double-ended queue with removal at any position.
// Commands arrive on the s_axis channel, one per transaction: the command code
// travels in tuser, the position and the element to append in tdata. Every
// command yields exactly one result transaction on m_axis, carrying a status
// in tuser and the element read or removed plus the new occupancy in tdata.
// Elements sit in a row of cells with the front in cell 0. A push writes the
// cell at the current count; any removal makes every cell from the removed
// place onwards take its right-hand neighbour's value in the same clock, so
// each command is fully executed in the cycle in which it is accepted.
// The result is offered in the cycle after acceptance, and the block takes one
// command per cycle while the receiver keeps up, limited by the shift of the
// cell row and the one result register.
// While a result waits for the receiver, a new command is still accepted in
// the cycle in which the waiting result is taken; if the receiver holds
// m_axis_tready low, s_axis_tready falls and the block holds its state.
// Reset empties the queue and drops any pending result; cell contents are not
// cleared, since no command can read past the occupancy.
module indexed_deque_with_removal import idq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [3:0] position, [35:4] write_data, [39:36] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] read_data, [36:32] occupancy, [39:37] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Handshake and unpacked command fields.
  logic              fire;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] wdata;

  // Control outputs.
  cell_op_t          op;
  logic [IDX_W-1:0]  tgt;
  cmd_res_t          res;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Cell row and its read selection.
  logic [WIDTH-1:0]  cell_data [DEPTH];
  logic [WIDTH-1:0]  cell_wdata;
  logic [WIDTH-1:0]  rd_word;

  // Result register.
  logic              vld_q;
  logic              vld_d;
  status_e           status_q;
  logic [DATA_W-1:0] rdata_q;
  logic [OCC_W-1:0]  occ_q;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser;
  assign pos           = s_axis_tdata[POS_W-1:0];
  assign wdata         = s_axis_tdata[POS_W+DATA_W-1:POS_W];
  assign cell_wdata    = WIDTH'(wdata);

  idq_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (cmd),
    .pos_i        (pos),
    .op_o         (op),
    .tgt_o        (tgt),
    .res_o        (res),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // The last cell has no right-hand neighbour; whatever it takes on a removal
  // lies beyond the new occupancy.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] next_data;
    if (i == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end
    idq_cell #(
      .WIDTH (WIDTH),
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .tgt_i   (tgt),
      .wdata_i (cell_wdata),
      .next_i  (next_data),
      .data_o  (cell_data[i])
    );
  end

  // The element concerned by a read or removal is the cell at the target index
  // (zero for a front pop, the last element for a back pop).
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | (cell_data[i] & {WIDTH{tgt == IDX_W'(i)}});
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (fire) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload of the result carries no reset.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res.status;
      rdata_q  <= res.rd_en ? DATA_W'(rd_word) : '0;
      occ_q    <= OCC_W'(count_next);
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, occ_q, rdata_q};

  // A failed command must report no element.
  `ASSERT_NEXT(a_err_zero_data, fire && !res.rd_en, m_axis_tdata[31:0] == 32'd0)
  // A successful push grows the queue by exactly one.
  `ASSERT_NEXT(a_push_grows, fire && op.push, count == $past(count) + CNT_W'(1))
  // The occupancy never exceeds the number of cells.
  `ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  // Elements are only delivered alongside an ok status.
  `ASSERT_SAME(a_rd_ok, fire && res.rd_en, res.status == ST_OK)

endmodule
